@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ design/smer_pkg.sv @@
package smer_pkg;

  // field and datapath widths
  localparam int COORD_W  = 11;
  localparam int STEP_W   = COORD_W + 1;
  localparam int OUT_W    = 13;
  localparam int SQ_W     = 22;
  localparam int DEC_W    = 48;
  localparam int MUL_W    = DEC_W / 2;
  localparam int STIP_LEN = 16;
  localparam int IDX_W    = $clog2(STIP_LEN);

  // request operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // shape phase
  typedef enum logic [1:0] {
    PH_REGION1 = 2'd0,
    PH_REGION2 = 2'd1,
    PH_LINE    = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_A_SB,
    MUL_A_Y,
    MUL_B_X1,
    MUL_B_2X3,
    MUL_A_22Y,
    MUL_B_2X2,
    MUL_A_32Y,
    MUL_XX,
    MUL_B_P,
    MUL_Y1Y1,
    MUL_A_P,
    MUL_A_B
  } mul_sel_t;

  // what to do with the registered product
  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_D_ADD,
    ACC_D_ADD_IF,
    ACC_D_FROM_B,
    ACC_TMP,
    ACC_TMP_ADD,
    ACC_D_FROM_TMP,
    ACC_A_SQ,
    ACC_B_SQ
  } acc_op_t;

  // state register updates
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_SETUP,
    UPD_STEP_START,
    UPD_R1_MOVE,
    UPD_R2_MOVE,
    UPD_R2_END,
    UPD_SETTLE_END,
    UPD_LINE
  } upd_t;

  typedef struct packed {
    logic     in_ready;
    logic     out_load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    upd_t     upd;
  } cmd_t;

  typedef struct packed {
    logic   in_valid;
    logic   operation;
    phase_t phase;
    logic   line_shape;
    logic   cmp;
    logic   out_free;
  } stat_t;

endpackage

@@ design/smer_shape_if.sv @@
interface smer_shape_if;
  import smer_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [COORD_W-1:0] corner_ax;
  logic [COORD_W-1:0] corner_ay;
  logic [COORD_W-1:0] corner_bx;
  logic [COORD_W-1:0] corner_by;
  logic [STIP_LEN-1:0] stipple;

  modport source (
    output valid, operation, corner_ax, corner_ay, corner_bx, corner_by, stipple,
    input  ready
  );

  modport sink (
    input  valid, operation, corner_ax, corner_ay, corner_bx, corner_by, stipple,
    output ready
  );

endinterface

@@ design/smer_point_if.sv @@
interface smer_point_if;
  import smer_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] right_x;
  logic signed [OUT_W-1:0] left_x;
  logic signed [OUT_W-1:0] lower_y;
  logic signed [OUT_W-1:0] upper_y;
  logic                    visible;
  logic                    last_point;

  modport source (
    output valid, right_x, left_x, lower_y, upper_y, visible, last_point,
    input  ready
  );

  modport sink (
    input  valid, right_x, left_x, lower_y, upper_y, visible, last_point,
    output ready
  );

endinterface

@@ design/smer_ctrl.sv @@
`include "assert_macros.svh"

module smer_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  smer_pkg::stat_t stat,
  output smer_pkg::cmd_t  cmd
);
  import smer_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_E_AA,
    S_E_BB,
    S_E_AB,
    S_E_D,
    S_R1_A,
    S_R1_B,
    S_R1_C,
    S_R1_D,
    S_R1_E,
    S_ST_1,
    S_ST_2,
    S_ST_3,
    S_ST_4,
    S_ST_5,
    S_ST_6,
    S_R2_A,
    S_R2_B,
    S_R2_C,
    S_L_STEP,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = stat.in_valid && cmd.in_ready;

  // sequencing and command decode
  always_comb begin
    state_next  = state;
    cmd.in_ready = 1'b0;
    cmd.out_load = 1'b0;
    cmd.mul_sel  = MUL_NONE;
    cmd.acc_op   = ACC_NONE;
    cmd.upd      = UPD_NONE;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          if (stat.operation == OP_START) begin
            state_next = S_SETUP;
          end else begin
            case (stat.phase)
              PH_LINE:    state_next = S_L_STEP;
              PH_REGION1: state_next = S_R1_A;
              PH_REGION2: state_next = S_R2_A;
              default:    state_next = S_IDLE;
            endcase
          end
        end
      end
      // start: centre, semi-axes or line end points
      S_SETUP: begin
        cmd.upd    = UPD_SETUP;
        state_next = stat.line_shape ? S_EMIT : S_E_AA;
      end
      S_E_AA: begin
        cmd.mul_sel = MUL_AA;
        state_next  = S_E_BB;
      end
      S_E_BB: begin
        cmd.acc_op  = ACC_A_SQ;
        cmd.mul_sel = MUL_BB;
        state_next  = S_E_AB;
      end
      S_E_AB: begin
        cmd.acc_op  = ACC_B_SQ;
        cmd.mul_sel = MUL_A_SB;
        state_next  = S_E_D;
      end
      S_E_D: begin
        cmd.acc_op  = ACC_D_FROM_B;
        cmd.mul_sel = MUL_A_Y;
        state_next  = S_R1_D;
      end
      // region 1 step
      S_R1_A: begin
        cmd.upd     = UPD_STEP_START;
        cmd.mul_sel = MUL_B_2X3;
        state_next  = S_R1_B;
      end
      S_R1_B: begin
        cmd.acc_op  = ACC_D_ADD;
        cmd.mul_sel = MUL_A_22Y;
        cmd.upd     = UPD_R1_MOVE;
        state_next  = S_R1_C;
      end
      S_R1_C: begin
        cmd.acc_op  = ACC_D_ADD_IF;
        cmd.mul_sel = MUL_A_Y;
        state_next  = S_R1_D;
      end
      S_R1_D: begin
        cmd.acc_op  = ACC_TMP;
        cmd.mul_sel = MUL_B_X1;
        state_next  = S_R1_E;
      end
      // still in region 1 when a2*y > b2*(x+1)
      S_R1_E: begin
        if (stat.cmp) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_ST_1;
        end
      end
      // region 2 entry: d = b2*x*x + a2*(y-1)^2 - a2*b2
      S_ST_1: begin
        cmd.mul_sel = MUL_XX;
        state_next  = S_ST_2;
      end
      S_ST_2: begin
        cmd.mul_sel = MUL_B_P;
        state_next  = S_ST_3;
      end
      S_ST_3: begin
        cmd.acc_op  = ACC_TMP;
        cmd.mul_sel = MUL_Y1Y1;
        state_next  = S_ST_4;
      end
      S_ST_4: begin
        cmd.mul_sel = MUL_A_P;
        state_next  = S_ST_5;
      end
      S_ST_5: begin
        cmd.acc_op  = ACC_TMP_ADD;
        cmd.mul_sel = MUL_A_B;
        state_next  = S_ST_6;
      end
      S_ST_6: begin
        cmd.acc_op = ACC_D_FROM_TMP;
        cmd.upd    = UPD_SETTLE_END;
        state_next = S_EMIT;
      end
      // region 2 step
      S_R2_A: begin
        cmd.upd     = UPD_STEP_START;
        cmd.mul_sel = MUL_B_2X2;
        state_next  = S_R2_B;
      end
      S_R2_B: begin
        cmd.acc_op  = ACC_D_ADD_IF;
        cmd.mul_sel = MUL_A_32Y;
        cmd.upd     = UPD_R2_MOVE;
        state_next  = S_R2_C;
      end
      S_R2_C: begin
        cmd.acc_op = ACC_D_ADD;
        cmd.upd    = UPD_R2_END;
        state_next = S_EMIT;
      end
      S_L_STEP: begin
        cmd.upd    = UPD_LINE;
        state_next = S_EMIT;
      end
      // result into the output register once it is free
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_NEVER(a_load_when_full, clk, rst, cmd.out_load && !stat.out_free)
  `ASSERT_AT(a_start_setup, clk, rst, (accept && (stat.operation == OP_START)) |=> (state == S_SETUP))
  `ASSERT_AT(a_done_drop, clk, rst, (accept && (stat.operation == OP_ADVANCE) && (stat.phase == PH_DONE)) |=> (state == S_IDLE))

endmodule

@@ design/smer_datapath.sv @@
`include "assert_macros.svh"

module smer_datapath (
  input  logic            clk,
  input  logic            rst,
  smer_shape_if.sink      shape,
  smer_point_if.source    point,
  input  smer_pkg::cmd_t  cmd,
  output smer_pkg::stat_t stat
);
  import smer_pkg::*;

  localparam logic signed [MUL_W-1:0] ONE   = MUL_W'(1);
  localparam logic signed [MUL_W-1:0] TWO   = MUL_W'(2);
  localparam logic signed [MUL_W-1:0] THREE = MUL_W'(3);

  // latched start request
  logic [COORD_W-1:0]  ax_q, ay_q, bx_q, by_q;
  logic [STIP_LEN-1:0] stipple_mask;

  // shape state
  logic [COORD_W-1:0]      centre_x, centre_y, semi_a, semi_b, line_end;
  logic [SQ_W-1:0]         a_sq, b_sq;
  logic [STEP_W-1:0]       step_x, step_y;
  logic signed [DEC_W-1:0] decision, temp, prod;
  phase_t                  phase;
  logic [IDX_W-1:0]        stipple_index;
  logic                    branch, line_mode, no_point;

  // output register
  logic out_valid;

  // setup terms
  logic [STEP_W-1:0]        sum_x, sum_y;
  logic [COORD_W-1:0]       cx_new, cy_new, semi_a_new, semi_b_new, lo, hi;
  logic signed [STEP_W-1:0] diff_a, diff_b, mag_a, mag_b;
  logic [STEP_W-1:0]        dy, lo_inc;
  logic                     line_shape, line_empty, line_short;

  // multiplier
  logic signed [MUL_W-1:0] x_ext, y_ext, a_ext, b_ext, sa_ext, sb_ext, prod_lo;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [DEC_W-1:0] mul_out;
  logic signed [DEC_W-1:0] b_sq_dec;

  // line step terms
  logic [STEP_W-1:0] x_inc;
  logic [STEP_W:0]   x_inc2;

  // output terms
  logic [OUT_W-1:0] rx_val, lx_val, ly_val, uy_val;

  assign shape.ready = cmd.in_ready;

  // capture corners and mask on an accepted start request
  always_ff @(posedge clk) begin
    if (shape.valid && shape.ready && (shape.operation == OP_START)) begin
      ax_q         <= shape.corner_ax;
      ay_q         <= shape.corner_ay;
      bx_q         <= shape.corner_bx;
      by_q         <= shape.corner_by;
      stipple_mask <= shape.stipple;
    end
  end

  // centre, semi-axes and line test
  always_comb begin
    sum_x      = STEP_W'(ax_q) + STEP_W'(bx_q);
    sum_y      = STEP_W'(ay_q) + STEP_W'(by_q);
    cx_new     = sum_x[STEP_W-1:1];
    cy_new     = sum_y[STEP_W-1:1];
    diff_a     = $signed(STEP_W'(bx_q)) - $signed(STEP_W'(cx_new));
    diff_b     = $signed(STEP_W'(by_q)) - $signed(STEP_W'(cy_new));
    mag_a      = diff_a[STEP_W-1] ? -diff_a : diff_a;
    mag_b      = diff_b[STEP_W-1] ? -diff_b : diff_b;
    semi_a_new = mag_a[COORD_W-1:0];
    semi_b_new = mag_b[COORD_W-1:0];
    dy         = STEP_W'(ay_q) - STEP_W'(by_q);
    line_shape = (dy == '0) || (dy == STEP_W'(1)) || (dy == '1);
    lo         = (ax_q < bx_q) ? ax_q : bx_q;
    hi         = (ax_q < bx_q) ? bx_q : ax_q;
    lo_inc     = STEP_W'(lo) + STEP_W'(1);
    line_empty = (lo == hi);
    line_short = (lo_inc == STEP_W'(hi));
  end

  // multiplier operand selection
  always_comb begin
    x_ext   = $signed(MUL_W'(step_x));
    y_ext   = $signed(MUL_W'(step_y));
    a_ext   = $signed(MUL_W'(a_sq));
    b_ext   = $signed(MUL_W'(b_sq));
    sa_ext  = $signed(MUL_W'(semi_a));
    sb_ext  = $signed(MUL_W'(semi_b));
    prod_lo = prod[MUL_W-1:0];
    case (cmd.mul_sel)
      MUL_AA: begin
        mul_a = sa_ext;
        mul_b = sa_ext;
      end
      MUL_BB: begin
        mul_a = sb_ext;
        mul_b = sb_ext;
      end
      MUL_A_SB: begin
        mul_a = a_ext;
        mul_b = sb_ext;
      end
      MUL_A_Y: begin
        mul_a = a_ext;
        mul_b = y_ext;
      end
      MUL_B_X1: begin
        mul_a = b_ext;
        mul_b = x_ext + ONE;
      end
      MUL_B_2X3: begin
        mul_a = b_ext;
        mul_b = x_ext + x_ext + THREE;
      end
      MUL_A_22Y: begin
        mul_a = a_ext;
        mul_b = TWO - y_ext - y_ext;
      end
      MUL_B_2X2: begin
        mul_a = b_ext;
        mul_b = x_ext + x_ext + TWO;
      end
      MUL_A_32Y: begin
        mul_a = a_ext;
        mul_b = THREE - y_ext - y_ext;
      end
      MUL_XX: begin
        mul_a = x_ext;
        mul_b = x_ext;
      end
      MUL_B_P: begin
        mul_a = b_ext;
        mul_b = prod_lo;
      end
      MUL_Y1Y1: begin
        mul_a = y_ext - ONE;
        mul_b = y_ext - ONE;
      end
      MUL_A_P: begin
        mul_a = a_ext;
        mul_b = prod_lo;
      end
      MUL_A_B: begin
        mul_a = a_ext;
        mul_b = b_ext;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out  = mul_a * mul_b;
  assign b_sq_dec = $signed(DEC_W'(b_sq));

  // product register and decision accumulation
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= mul_out;
    end
    case (cmd.acc_op)
      ACC_D_ADD:      decision <= decision + prod;
      ACC_D_ADD_IF:   if (branch) decision <= decision + prod;
      ACC_D_FROM_B:   decision <= b_sq_dec - prod;
      ACC_TMP:        temp <= prod;
      ACC_TMP_ADD:    temp <= temp + prod;
      ACC_D_FROM_TMP: decision <= temp - prod;
      ACC_A_SQ:       a_sq <= prod[SQ_W-1:0];
      ACC_B_SQ:       b_sq <= prod[SQ_W-1:0];
      default: begin
      end
    endcase
  end

  // line step terms
  assign x_inc  = step_x + STEP_W'(1);
  assign x_inc2 = (STEP_W+1)'(x_inc) + (STEP_W+1)'(1);

  // shape state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      line_mode <= 1'b0;
    end else begin
      case (cmd.upd)
        UPD_SETUP: begin
          stipple_index <= '0;
          centre_x      <= cx_new;
          centre_y      <= cy_new;
          if (line_shape) begin
            line_mode <= 1'b1;
            no_point  <= line_empty;
            step_x    <= STEP_W'(lo);
            step_y    <= STEP_W'(ay_q);
            line_end  <= hi;
            phase     <= (line_empty || line_short) ? PH_DONE : PH_LINE;
          end else begin
            line_mode <= 1'b0;
            no_point  <= 1'b0;
            semi_a    <= semi_a_new;
            semi_b    <= semi_b_new;
            step_x    <= '0;
            step_y    <= STEP_W'(semi_b_new);
            phase     <= PH_REGION1;
          end
        end
        UPD_STEP_START: begin
          stipple_index <= stipple_index + IDX_W'(1);
          branch <= (phase == PH_REGION1) ? !decision[DEC_W-1] : decision[DEC_W-1];
        end
        UPD_R1_MOVE: begin
          step_x <= step_x + STEP_W'(1);
          step_y <= step_y - STEP_W'(branch);
        end
        UPD_R2_MOVE: begin
          step_x <= step_x + STEP_W'(branch);
          step_y <= step_y - STEP_W'(1);
        end
        UPD_R2_END: begin
          if (step_y == '0) phase <= PH_DONE;
        end
        UPD_SETTLE_END: begin
          phase <= (step_y != '0) ? PH_REGION2 : PH_DONE;
        end
        UPD_LINE: begin
          step_x        <= x_inc;
          stipple_index <= stipple_index + IDX_W'(1);
          if (x_inc2 >= (STEP_W+1)'(line_end)) phase <= PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  // point coordinates from the current state
  always_comb begin
    if (line_mode) begin
      rx_val = OUT_W'(step_x);
      lx_val = OUT_W'(step_x);
      ly_val = OUT_W'(step_y);
      uy_val = OUT_W'(step_y);
    end else begin
      rx_val = OUT_W'(centre_x) + OUT_W'(step_x);
      lx_val = OUT_W'(centre_x) - OUT_W'(step_x);
      ly_val = OUT_W'(centre_y) + OUT_W'(step_y);
      uy_val = OUT_W'(centre_y) - OUT_W'(step_y);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (point.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point.right_x    <= rx_val;
      point.left_x     <= lx_val;
      point.lower_y    <= ly_val;
      point.upper_y    <= uy_val;
      point.visible    <= stipple_mask[stipple_index] & ~no_point;
      point.last_point <= (phase == PH_DONE);
    end
  end

  assign point.valid = out_valid;

  // status to the controller
  assign stat.in_valid   = shape.valid;
  assign stat.operation  = shape.operation;
  assign stat.phase      = phase;
  assign stat.line_shape = line_shape;
  assign stat.cmp        = temp > prod;
  assign stat.out_free   = !out_valid || point.ready;

  `ASSERT_NEVER(a_line_phase_mode, clk, rst, (phase == PH_LINE) && !line_mode)
  `ASSERT_NEVER(a_region_not_line, clk, rst, ((phase == PH_REGION1) || (phase == PH_REGION2)) && line_mode)
  `ASSERT_AT(a_settle_from_r1, clk, rst, (cmd.upd == UPD_SETTLE_END) |-> (phase == PH_REGION1))

endmodule

@@ design/stippled_midpoint_ellipse_raster.sv @@
// channel | dir | payload                                          | request means
// shape   | in  | operation, corner_ax/ay/bx/by, stipple           | start a shape or advance
// point   | out | right_x, left_x, lower_y, upper_y, visible, last | one rasterized point
//
// a new request is taken only in idle, once the last one is through; an advance with no
// shape active makes no point. One shared 24x24 multiplier gives one product a cycle.
// reset is synchronous on rst; no memory to clear.
// a point waiting in the output register does not block a new request; the next point
// holds in its last step until the register is free.
module stippled_midpoint_ellipse_raster (
  input logic          clk,
  input logic          rst,
  smer_shape_if.sink   shape,
  smer_point_if.source point
);
  import smer_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  smer_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // arithmetic and shape state
  smer_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .shape (shape),
    .point (point),
    .cmd   (cmd),
    .stat  (stat)
  );

endmodule

@@ tb/raster_point_checker.sv @@
module raster_point_checker (
  input  logic  clk,
  input  logic  rst,
  smer_shape_if shape,
  smer_point_if point,
  output int    error_count,
  output int    points_owed,
  output logic  shape_open
);
  import smer_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] lower_y;
    logic signed [OUT_W-1:0] upper_y;
    logic                    visible;
    logic                    last_point;
  } point_t;

  // predicted rasterizer state, decision terms kept exact in 64 bits
  longint              cen_x, cen_y;
  longint              a_sq, b_sq;
  longint              off_x, off_y;
  longint              decision;
  longint              line_stop;
  phase_t              phase_now;
  logic [IDX_W-1:0]    stip_idx;
  logic [STIP_LEN-1:0] stip_mask;

  point_t pending_points[$];

  assign shape_open = (phase_now != PH_DONE);

  function automatic point_t pack_point(input longint rx, input longint lx, input longint ly,
                                        input longint uy, input logic vis, input logic last);
    point_t p;
    p.right_x    = rx[OUT_W-1:0];
    p.left_x     = lx[OUT_W-1:0];
    p.lower_y    = ly[OUT_W-1:0];
    p.upper_y    = uy[OUT_W-1:0];
    p.visible    = vis;
    p.last_point = last;
    return p;
  endfunction

  function automatic logic stipple_on();
    return stip_mask[stip_idx];
  endfunction

  function automatic point_t ellipse_point();
    return pack_point(cen_x + off_x, cen_x - off_x, cen_y + off_y, cen_y - off_y,
                      stipple_on(), phase_now == PH_DONE);
  endfunction

  // switch to region 2 once the region 1 slope test fails
  function automatic void leave_region1();
    if (phase_now != PH_REGION1) return;
    if (a_sq * off_y > b_sq * (off_x + 1)) return;
    decision = b_sq * off_x * off_x + a_sq * (off_y - 1) * (off_y - 1) - a_sq * b_sq;
    phase_now = (off_y > 0) ? PH_REGION2 : PH_DONE;
  endfunction

  // one shape request: start from corners or advance one step
  function automatic void raster_request(input logic op,
                                         input logic [COORD_W-1:0] ax_in,
                                         input logic [COORD_W-1:0] ay_in,
                                         input logic [COORD_W-1:0] bx_in,
                                         input logic [COORD_W-1:0] by_in,
                                         input logic [STIP_LEN-1:0] stip,
                                         output bit made, output point_t pt);
    longint ax, ay, bx, by, dy, lo, hi, a, b;
    ax = ax_in;
    ay = ay_in;
    bx = bx_in;
    by = by_in;
    made = 1'b1;
    pt = '0;
    if (op == OP_START) begin
      dy = ay - by;
      stip_mask = stip;
      stip_idx = '0;
      cen_x = (ax + bx) / 2;
      cen_y = (ay + by) / 2;
      if (dy >= -1 && dy <= 1) begin
        // flat shape: horizontal line walk, end column excluded
        lo = (ax < bx) ? ax : bx;
        hi = (ax < bx) ? bx : ax;
        off_x = lo;
        off_y = ay;
        line_stop = hi;
        decision = 0;
        a_sq = 0;
        b_sq = 0;
        if (lo == hi) begin
          phase_now = PH_DONE;
          pt = pack_point(lo, lo, ay, ay, 1'b0, 1'b1);
        end else begin
          phase_now = (lo + 1 == hi) ? PH_DONE : PH_LINE;
          pt = pack_point(lo, lo, ay, ay, stipple_on(), phase_now == PH_DONE);
        end
      end else begin
        a = bx - cen_x;
        b = by - cen_y;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        a_sq = a * a;
        b_sq = b * b;
        off_x = 0;
        off_y = b;
        decision = b_sq - a_sq * b;
        line_stop = 0;
        phase_now = PH_REGION1;
        leave_region1();
        pt = ellipse_point();
      end
    end else begin
      case (phase_now)
        PH_LINE: begin
          off_x++;
          stip_idx++;
          if (off_x + 1 >= line_stop) phase_now = PH_DONE;
          pt = pack_point(off_x, off_x, off_y, off_y, stipple_on(), phase_now == PH_DONE);
        end
        PH_REGION1: begin
          stip_idx++;
          if (decision < 0) begin
            decision += b_sq * (2 * off_x + 3);
          end else begin
            decision += b_sq * (2 * off_x + 3) + a_sq * (2 - 2 * off_y);
            off_y--;
          end
          off_x++;
          leave_region1();
          pt = ellipse_point();
        end
        PH_REGION2: begin
          stip_idx++;
          if (decision < 0) begin
            decision += b_sq * (2 * off_x + 2) + a_sq * (3 - 2 * off_y);
            off_x++;
          end else begin
            decision += a_sq * (3 - 2 * off_y);
          end
          off_y--;
          if (off_y <= 0) phase_now = PH_DONE;
          pt = ellipse_point();
        end
        default: begin
          made = 1'b0;
        end
      endcase
    end
  endfunction

  function automatic void report_fault(input string what, input point_t want,
                                       input point_t got);
    error_count++;
    if (error_count <= 10)
      $display({"%0t %s: want rx=%0d lx=%0d ly=%0d uy=%0d vis=%0b last=%0b",
                " | got rx=%0d lx=%0d ly=%0d uy=%0d vis=%0b last=%0b"},
               $realtime, what, want.right_x, want.left_x, want.lower_y, want.upper_y,
               want.visible, want.last_point, got.right_x, got.left_x, got.lower_y,
               got.upper_y, got.visible, got.last_point);
  endfunction

  initial begin
    error_count = 0;
    points_owed = 0;
    phase_now = PH_DONE;
  end

  // compare accepted points, then predict accepted requests
  always @(posedge clk) begin
    point_t got, want;
    bit     made;
    if (rst) begin
      cen_x = 0;
      cen_y = 0;
      a_sq = 0;
      b_sq = 0;
      off_x = 0;
      off_y = 0;
      decision = 0;
      line_stop = 0;
      phase_now = PH_DONE;
      stip_idx = '0;
      stip_mask = '0;
      pending_points.delete();
    end else begin
      if (point.valid && point.ready) begin
        got = '{point.right_x, point.left_x, point.lower_y, point.upper_y,
                point.visible, point.last_point};
        if (pending_points.size() == 0) begin
          report_fault("unexpected point", '0, got);
        end else begin
          want = pending_points.pop_front();
          if (got !== want) report_fault("point mismatch", want, got);
        end
      end
      if (shape.valid && shape.ready) begin
        raster_request(shape.operation, shape.corner_ax, shape.corner_ay, shape.corner_bx,
                       shape.corner_by, shape.stipple, made, want);
        if (made) pending_points.push_back(want);
      end
    end
    points_owed = pending_points.size();
  end

endmodule

@@ tb/tb_stippled_midpoint_ellipse_raster.sv @@
module tb_stippled_midpoint_ellipse_raster;
  import smer_pkg::*;

  logic clk;
  logic rst;
  logic calm;
  int   error_count;
  int   points_owed;
  logic shape_open;
  int   shape_requests;

  smer_shape_if shape_ch ();
  smer_point_if point_ch ();

  stippled_midpoint_ellipse_raster dut (
    .clk   (clk),
    .rst   (rst),
    .shape (shape_ch),
    .point (point_ch)
  );

  raster_point_checker chk (
    .clk         (clk),
    .rst         (rst),
    .shape       (shape_ch),
    .point       (point_ch),
    .error_count (error_count),
    .points_owed (points_owed),
    .shape_open  (shape_open)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // point sink: random stall bursts, always ready near the end
  initial begin
    point_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 2) != 0) begin
        point_ch.ready = 1'b1;
        repeat ($urandom_range(0, 19)) @(negedge clk);
      end else begin
        point_ch.ready = 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end
    end
  end

  // one request, entered and left at a falling edge
  task automatic send_request(input logic op, input logic [COORD_W-1:0] ax,
                              input logic [COORD_W-1:0] ay, input logic [COORD_W-1:0] bx,
                              input logic [COORD_W-1:0] by, input logic [STIP_LEN-1:0] stip);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      shape_ch.valid = 1'b0;
      shape_ch.operation = 1'($urandom);
      shape_ch.corner_ax = COORD_W'($urandom);
      shape_ch.corner_ay = COORD_W'($urandom);
      shape_ch.corner_bx = COORD_W'($urandom);
      shape_ch.corner_by = COORD_W'($urandom);
      shape_ch.stipple = STIP_LEN'($urandom);
      repeat (gap) @(negedge clk);
    end
    shape_ch.operation = op;
    shape_ch.corner_ax = ax;
    shape_ch.corner_ay = ay;
    shape_ch.corner_bx = bx;
    shape_ch.corner_by = by;
    shape_ch.stipple = stip;
    shape_ch.valid = 1'b1;
    do @(posedge clk); while (!shape_ch.ready);
    @(negedge clk);
  endtask

  // advance with junk in the corner fields
  task automatic send_advance();
    send_request(OP_ADVANCE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom), STIP_LEN'($urandom));
  endtask

  // start a shape and step it until it ends or the step budget runs out
  task automatic trace_shape(input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
                             input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                             input logic [STIP_LEN-1:0] stip, input int max_steps);
    int steps;
    steps = 0;
    send_request(OP_START, ax, ay, bx, by, stip);
    shape_requests++;
    while (shape_open && steps < max_steps) begin
      send_advance();
      shape_requests++;
      steps++;
    end
  endtask

  // coordinate within span of base, clipped to the field range
  function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] base, input int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return v[COORD_W-1:0];
  endfunction

  initial begin
    logic [COORD_W-1:0] ax, ay, bx, by;
    int                 kind;
    int                 budget;
    rst = 1'b1;
    calm = 1'b0;
    shape_requests = 0;
    shape_ch.valid = 1'b0;
    shape_ch.operation = OP_START;
    shape_ch.corner_ax = '0;
    shape_ch.corner_ay = '0;
    shape_ch.corner_bx = '0;
    shape_ch.corner_by = '0;
    shape_ch.stipple = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle advances, degenerate lines, extreme corners, restarts
    send_advance();
    trace_shape(11'd100, 11'd50, 11'd100, 11'd50, 16'hFFFF, 0);
    send_advance();
    trace_shape(11'd7, 11'd3, 11'd8, 11'd4, 16'h0001, 5);
    trace_shape(11'd2047, 11'd2047, 11'd0, 11'd2046, 16'hAAAA, 3);
    trace_shape(11'd0, 11'd0, 11'd2047, 11'd2047, 16'h5555, 3);
    trace_shape(11'd2047, 11'd2047, 11'd0, 11'd0, 16'h0000, 2);
    trace_shape(11'd5, 11'd5, 11'd5, 11'd9, 16'hFFFF, 1 << 20);
    trace_shape(11'd20, 11'd30, 11'd24, 11'd34, 16'hF0F0, 1 << 20);
    trace_shape(11'd2047, 11'd0, 11'd2040, 11'd6, 16'h8001, 1 << 20);

    // random shapes, mostly small and run to the end
    while (shape_requests < 1525) begin
      calm = (shape_requests > 1250);
      kind = $urandom_range(0, 99);
      ax = COORD_W'($urandom);
      ay = COORD_W'($urandom);
      budget = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 10)) : (1 << 20);
      if (kind < 55) begin
        bx = near(ax, 8);
        by = near(ay, 10);
      end else if (kind < 70) begin
        bx = near(ax, 40);
        by = near(ay, 40);
      end else if (kind < 85) begin
        bx = ($urandom_range(0, 4) == 0) ? ax : near(ax, 40);
        by = near(ay, 1);
      end else begin
        bx = COORD_W'($urandom);
        by = COORD_W'($urandom);
        budget = $urandom_range(0, 40);
      end
      trace_shape(ax, ay, bx, by, STIP_LEN'($urandom), budget);
      // stray advance, often with no shape left to step
      if ($urandom_range(0, 9) == 0) begin
        if (shape_open) shape_requests++;
        send_advance();
      end
    end
    shape_ch.valid = 1'b0;

    wait (points_owed == 0);
    repeat (40) @(posedge clk);
    if (error_count == 0 && points_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
